// File: src/mhpq_pkg.sv
// Package for the max-heap priority queue: sizes, codes, item structs and
// the sequencer state type. No dependencies.
package mhpq_pkg;

  localparam int DEPTH   = 64;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CHILD_W = ADDR_W + 2;
  localparam int CAP_W   = 7;
  localparam int ELEM_W  = 7;
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  // register index taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic MODE_INSERT  = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                     mode;
    logic signed [DATA_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic signed [DATA_W-1:0] top_value;
    logic [ELEM_W-1:0]        element_count;
    logic [1:0]               status;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_V,
    S_DN_L,
    S_DN_R,
    S_DN_CMP,
    S_DONE
  } state_t;

endpackage

// File: src/max_heap_priority_queue_top.sv
// Max-heap priority queue over a single synchronous heap memory.
// Depends on mhpq_pkg for sizes, codes, item structs and the state type.
//
//   channel   direction  handshake                 payload
//   item in   in         start, accepted if !busy  item_in  (in_item_t)
//   result    out        done, one cycle strobe    result   (out_item_t)
//   config    in/out     APB psel/penable/pwrite   paddr, pwdata, prdata
//
// A refused item (full or empty) goes from accept straight to the result. An insert
// climbs by reading the parent and comparing, pulling the parent down while smaller.
// An extract of the last element goes straight to the result; any other extract
// fetches the last entry, then reads the left child, the right child and compares
// at each level descended. The single read port of the heap memory sets these steps.
// Synchronous reset empties the queue and sets capacity to 64; the memory
// itself is not cleared. The result is shown for one cycle with done and busy
// drops the cycle after; the receiver cannot stall.
module max_heap_priority_queue_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  mhpq_pkg::in_item_t               item_in,
  output logic                             busy,
  output logic                             done,
  output mhpq_pkg::out_item_t              result,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mhpq_pkg::PADDR_W-1:0]     paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import mhpq_pkg::*;

  state_t state, state_next;

  logic [CAP_W-1:0]         capacity;
  logic [CNT_W-1:0]         count, count_next;
  logic [ADDR_W-1:0]        pos, pos_next;
  logic signed [DATA_W-1:0] v, v_next;
  logic signed [DATA_W-1:0] lval, lval_next;
  logic                     has_r, has_r_next;
  logic signed [DATA_W-1:0] top;
  logic signed [DATA_W-1:0] popped, popped_next;
  logic [1:0]               status, status_next;

  logic signed [DATA_W-1:0] heap_mem [DEPTH];
  logic                     we;
  logic [ADDR_W-1:0]        waddr;
  logic signed [DATA_W-1:0] wdata;
  logic                     ren;
  logic [ADDR_W-1:0]        raddr;
  logic signed [DATA_W-1:0] rdata;

  logic                     full;
  logic [ADDR_W-1:0]        parent;
  logic [CHILD_W-1:0]       lidx, ridx, cnt_c;
  logic                     move_l, move_r;
  logic signed [DATA_W-1:0] best_val;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(capacity) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_CAPACITY) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  // heap memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      heap_mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ren) begin
      rdata <= heap_mem[raddr];
    end
  end

  // shadow of the root entry
  always_ff @(posedge clk) begin
    if (we && waddr == '0) begin
      top <= wdata;
    end
  end

  assign full   = (CMP_W'(count) >= CMP_W'(capacity)) || (count >= CNT_W'(DEPTH));
  assign parent = ADDR_W'((pos - ADDR_W'(1)) >> 1);
  assign lidx   = CHILD_W'({pos, 1'b1});
  assign ridx   = lidx + CHILD_W'(1);
  assign cnt_c  = CHILD_W'(count);

  assign move_l   = lval > v;
  assign best_val = move_l ? lval : v;
  assign move_r   = has_r && (rdata > best_val);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    pos    <= pos_next;
    v      <= v_next;
    lval   <= lval_next;
    has_r  <= has_r_next;
    popped <= popped_next;
    status <= status_next;
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    pos_next    = pos;
    v_next      = v;
    lval_next   = lval;
    has_r_next  = has_r;
    popped_next = popped;
    status_next = status;
    we          = 1'b0;
    waddr       = pos;
    wdata       = v;
    ren         = 1'b0;
    raddr       = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          popped_next = '0;
          status_next = ST_OK;
          if (item_in.mode == MODE_INSERT) begin
            if (full) begin
              status_next = ST_FULL;
              state_next  = S_DONE;
            end else begin
              count_next = count + CNT_W'(1);
              pos_next   = ADDR_W'(count);
              v_next     = item_in.push_value;
              state_next = S_UP_RD;
            end
          end else begin
            if (count == '0) begin
              status_next = ST_EMPTY;
              state_next  = S_DONE;
            end else begin
              popped_next = top;
              count_next  = count - CNT_W'(1);
              if (count == CNT_W'(1)) begin
                state_next = S_DONE;
              end else begin
                // fetch the last entry; it becomes the hole value at the root
                ren        = 1'b1;
                raddr      = ADDR_W'(count - CNT_W'(1));
                pos_next   = '0;
                state_next = S_DN_V;
              end
            end
          end
        end
      end
      S_UP_RD: begin
        if (pos == '0) begin
          we         = 1'b1;
          state_next = S_DONE;
        end else begin
          ren        = 1'b1;
          raddr      = parent;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (v > rdata) begin
          // pull the parent down into the hole and climb
          wdata      = rdata;
          pos_next   = parent;
          state_next = S_UP_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DN_V: begin
        v_next     = rdata;
        state_next = S_DN_L;
      end
      S_DN_L: begin
        if (lidx >= cnt_c) begin
          we         = 1'b1;
          state_next = S_DONE;
        end else begin
          ren        = 1'b1;
          raddr      = lidx[ADDR_W-1:0];
          state_next = S_DN_R;
        end
      end
      S_DN_R: begin
        lval_next  = rdata;
        has_r_next = ridx < cnt_c;
        if (ridx < cnt_c) begin
          ren   = 1'b1;
          raddr = ridx[ADDR_W-1:0];
        end
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (move_r) begin
          wdata      = rdata;
          pos_next   = ridx[ADDR_W-1:0];
          state_next = S_DN_L;
        end else if (move_l) begin
          wdata      = lval;
          pos_next   = lidx[ADDR_W-1:0];
          state_next = S_DN_L;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  always_comb begin
    result.popped_value  = popped;
    result.top_value     = (count != '0) ? top : '0;
    result.element_count = ELEM_W'(count);
    result.status        = status;
  end

  a_done_busy : assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe outside a busy period");

  a_count_range : assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("element count above store depth");

  a_empty_count : assert property (@(posedge clk) disable iff (rst)
    done && status == ST_EMPTY |-> count == '0)
    else $error("empty status with stored elements");

  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not start work");

  a_done_single : assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

endmodule

// File: verif/tb.sv
// Self-checking bench for max_heap_priority_queue_top: random and directed
// insert/extract items checked against a shadow heap. Depends on mhpq_pkg.
module tb;
  import mhpq_pkg::*;

  logic              clk;
  logic              rst;
  logic              start;
  in_item_t          item_in;
  logic              busy;
  logic              done;
  out_item_t         result;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  max_heap_priority_queue_top dut (
    .clk(clk), .rst(rst), .start(start), .item_in(item_in), .busy(busy),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  // shadow copy of the heap contents and the capacity register
  logic signed [DATA_W-1:0] shadow_heap [DEPTH];
  int                       shadow_count;
  logic [CAP_W-1:0]         shadow_cap;

  in_item_t  op_queue [$];
  out_item_t awaited_results [$];
  int        gap_pct;
  int        mismatches;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

  // Apply one operation to the shadow heap and return the result it must give.
  function automatic out_item_t heap_apply_op(in_item_t op);
    out_item_t             res;
    int                    eff_cap;
    int                    pos;
    int                    up;
    int                    best;
    int                    lc;
    int                    rc;
    bit                    walking;
    logic signed [DATA_W-1:0] tmp;
    res = '0;
    res.status = ST_OK;
    eff_cap = (int'(shadow_cap) > DEPTH) ? DEPTH : int'(shadow_cap);
    if (op.mode == MODE_INSERT) begin
      if (shadow_count >= eff_cap) begin
        res.status = ST_FULL;
      end else begin
        shadow_heap[shadow_count] = op.push_value;
        pos = shadow_count;
        shadow_count++;
        walking = 1'b1;
        while (walking && pos > 0) begin
          up = (pos - 1) / 2;
          if (shadow_heap[pos] > shadow_heap[up]) begin
            tmp = shadow_heap[pos];
            shadow_heap[pos] = shadow_heap[up];
            shadow_heap[up] = tmp;
            pos = up;
          end else begin
            walking = 1'b0;
          end
        end
      end
    end else begin
      if (shadow_count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.popped_value = shadow_heap[0];
        shadow_heap[0] = shadow_heap[shadow_count - 1];
        shadow_count--;
        pos = 0;
        walking = 1'b1;
        while (walking) begin
          best = pos;
          lc = 2 * pos + 1;
          rc = 2 * pos + 2;
          // strict compare keeps the left child on a tie
          if (lc < shadow_count && shadow_heap[lc] > shadow_heap[best]) best = lc;
          if (rc < shadow_count && shadow_heap[rc] > shadow_heap[best]) best = rc;
          if (best == pos) begin
            walking = 1'b0;
          end else begin
            tmp = shadow_heap[pos];
            shadow_heap[pos] = shadow_heap[best];
            shadow_heap[best] = tmp;
            pos = best;
          end
        end
      end
    end
    res.top_value = (shadow_count > 0) ? shadow_heap[0] : '0;
    res.element_count = ELEM_W'(shadow_count);
    return res;
  endfunction

  // Item driver: predict on acceptance, then present the next item or idle.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        awaited_results.push_back(heap_apply_op(item_in));
      end
      if (!start || !busy) begin
        if (op_queue.size() > 0 && $urandom_range(99) >= gap_pct) begin
          start   <= 1'b1;
          item_in <= op_queue.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor: every strobe must match the oldest awaited result.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        $error("result with no item pending: popped %0d top %0d count %0d status %0d",
               result.popped_value, result.top_value, result.element_count,
               result.status);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (result.popped_value !== want.popped_value) begin
          $error("popped_value: expected %0d, got %0d", want.popped_value,
                 result.popped_value);
          mismatches++;
        end
        if (result.top_value !== want.top_value) begin
          $error("top_value: expected %0d, got %0d", want.top_value, result.top_value);
          mismatches++;
        end
        if (result.element_count !== want.element_count) begin
          $error("element_count: expected %0d, got %0d", want.element_count,
                 result.element_count);
          mismatches++;
        end
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          mismatches++;
        end
      end
    end
  end

  task automatic queue_op(logic m, logic signed [DATA_W-1:0] v);
    in_item_t op;
    op.mode = m;
    op.push_value = v;
    op_queue.push_back(op);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(3))
      0: v = DATA_W'($urandom_range(6)) - DATA_W'(3);  // dense duplicates
      1: begin
        case ($urandom_range(3))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'h7FFF_FFFE;
          default: v = 32'h8000_0001;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic queue_random(int n, int insert_pct);
    for (int i = 0; i < n; i++) begin
      queue_op(($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_EXTRACT,
               pick_value());
    end
  endtask

  // Hold until every queued item is accepted and every result has come back.
  task automatic drain();
    while (op_queue.size() != 0 || start || awaited_results.size() != 0 || busy)
      @(negedge clk);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] cap);
    drain();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CAPACITY, 2'b00};
    pwdata  <= 32'(cap);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow_cap = cap;
  endtask

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    item_in      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    shadow_count = 0;
    shadow_cap   = CAP_RESET;
    gap_pct      = 0;
    mismatches   = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: empty extract, extremes, ties, drain to empty
    queue_op(MODE_EXTRACT, 32'h1234_5678);
    queue_op(MODE_INSERT, 32'sd0);
    queue_op(MODE_INSERT, 32'h7FFF_FFFF);
    queue_op(MODE_INSERT, 32'h8000_0000);
    queue_op(MODE_INSERT, -32'sd1);
    queue_op(MODE_INSERT, 32'sd1);
    queue_op(MODE_INSERT, 32'sd5);
    queue_op(MODE_INSERT, 32'sd5);
    queue_op(MODE_INSERT, 32'sd5);
    for (int i = 0; i < 9; i++) queue_op(MODE_EXTRACT, 32'hFFFF_FFFF);
    queue_op(MODE_INSERT, 32'h8000_0000);
    queue_op(MODE_INSERT, 32'h8000_0000);
    queue_op(MODE_EXTRACT, 32'sd0);
    queue_op(MODE_EXTRACT, 32'sd0);
    queue_op(MODE_EXTRACT, 32'sd0);

    // single entry: second insert is refused
    set_capacity(CAP_W'(1));
    queue_op(MODE_INSERT, 32'sd7);
    queue_op(MODE_INSERT, 32'sd8);
    queue_op(MODE_EXTRACT, 32'sd0);
    queue_op(MODE_EXTRACT, 32'sd0);

    // zero capacity refuses every insert
    set_capacity(CAP_W'(0));
    queue_op(MODE_INSERT, 32'sd9);
    queue_op(MODE_EXTRACT, 32'sd0);

    // random phases; insert bias drives the heap to full
    set_capacity(CAP_W'(64));
    gap_pct = 0;
    queue_random(200, 75);

    // capacity above the store depth acts as the depth
    set_capacity(CAP_W'(127));
    gap_pct = 45;
    queue_random(75, 60);
    drain();
    queue_random(75, 60);

    // lower capacity below the current fill level
    set_capacity(CAP_W'(5));
    gap_pct = 13;
    queue_random(100, 35);

    set_capacity(CAP_W'(1));
    gap_pct = 45;
    queue_random(60, 50);

    set_capacity(CAP_W'(0));
    gap_pct = 0;
    queue_random(40, 50);

    set_capacity(CAP_W'(33));
    gap_pct = 13;
    queue_random(150, 60);

    set_capacity(CAP_W'(64));
    gap_pct = 45;
    queue_random(100, 55);
    gap_pct = 0;
    queue_random(50, 45);

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
